// ===== rtl/sknt_pkg.sv =====
// Shared types and constants for the sorted key node table.
// Used by sknt_ctrl, sknt_datapath and sorted_key_node_table; no dependencies.
package sknt_pkg;

  // Default sizing of the node
  localparam int unsigned MaxEntriesDef = 256;
  localparam int unsigned ValueBitsDef  = 64;

  // Capacity register after reset
  localparam logic [8:0] CapReset = 9'd256;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOWER  = 2'd1,
    OP_UPPER  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_FETCH,
    S_SHIFT,
    S_INS
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    clear;       // empty the node
    logic    load;        // capture request, open search window
    logic    srch_rd;     // read probe slot
    logic    srch_step;   // narrow window after a probe miss
    logic    fetch_rd;    // read the bracket slot of a lookup
    logic    shift_init;  // start moving entries up from the top
    logic    shift_step;  // move one entry up
    logic    ins_wr;      // write the new entry at its slot
    logic    upd_wr;      // overwrite the value at the hit slot
    logic    emit;        // load the result registers
    status_e status;      // status of the emitted result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_e  op;          // operation of the request in flight
    logic open;        // search window still holds a probe
    logic hit;         // probed key equals the search key
    logic full;        // count has reached the capacity in effect
    logic pos_lt_cnt;  // insert slot lies below the count
    logic shift_last;  // shift pointer has reached the insert slot
    logic lb_miss;     // no key at or below the target
    logic ub_miss;     // no key at or above the target
  } node_stat_t;

endpackage

// ===== rtl/sorted_key_node_table.sv =====
// Top level of the sorted key node table: one B-tree leaf as a sorted key/value array.
// Depends on sknt_pkg, sknt_ctrl and sknt_datapath.
//
//  channel   direction  handshake               payload
//  request   in         start & !busy           operation_i, search_key_i, entry_value_i
//  result    out        done_o, one cycle       status_o, result_index_o, found_key_o,
//                                               result_value_o, entry_count_o
//  config    in         cfg_we_i                cfg_wdata_i (capacity limit)
//
// Steps: a clear is done in its accepting cycle. Any other request runs a binary
// search, each probe a memory read (S_SEARCH) then a compare (S_CMP), at most
// ceil(log2(count+1)) probes; an exact hit ends there, otherwise S_SEARCH closes the
// window and a bracket lookup adds a fetch (S_FETCH). A new key below the top moves
// count - slot entries up in S_SHIFT, one entry per cycle, reading one slot while
// writing another, then is written in S_INS; at the top it is written as the window closes.
// The result appears on the cycle after the last step, as busy drops (a clear never raises busy).
// Reset clears the count and sets the capacity limit to 256; memories are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module sorted_key_node_table import sknt_pkg::*; #(
  parameter int unsigned NODE_DEPTH = MaxEntriesDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic [63:0]       search_key_i,
  input  logic [63:0]       entry_value_i,
  input  logic              cfg_we_i,
  input  logic [8:0]        cfg_wdata_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic signed [9:0] result_index_o,
  output logic [63:0]       found_key_o,
  output logic [63:0]       result_value_o,
  output logic [8:0]        entry_count_o
);

  cmd_t       cmd;
  node_stat_t stat;

  // Sequencer
  sknt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_e'(operation_i)),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Storage and arithmetic
  sknt_datapath #(
    .NODE_DEPTH (NODE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .operation_i    (operation_i),
    .search_key_i   (search_key_i),
    .entry_value_i  (entry_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .result_index_o (result_index_o),
    .found_key_o    (found_key_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

// ===== rtl/sknt_ctrl.sv =====
// Controller state machine of the sorted key node table.
// Depends on sknt_pkg; drives sknt_datapath through cmd_t and reads node_stat_t.
module sknt_ctrl import sknt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  op_e        op_i,
  input  node_stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       busy
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (op_i == OP_CLEAR) begin
            cmd_o.clear  = 1'b1;
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_CLEARED;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (stat_i.open) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_CMP;
        end else begin
          // window closed without a hit
          state_d = S_IDLE;
          unique case (stat_i.op)
            OP_INSERT: begin
              if (stat_i.full) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = ST_FULL;
              end else if (stat_i.pos_lt_cnt) begin
                cmd_o.shift_init = 1'b1;
                state_d          = S_SHIFT;
              end else begin
                cmd_o.ins_wr = 1'b1;
                cmd_o.emit   = 1'b1;
                cmd_o.status = ST_INSERTED;
              end
            end
            OP_LOWER, OP_UPPER: begin
              if ((stat_i.op == OP_LOWER) ? stat_i.lb_miss : stat_i.ub_miss) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = ST_NOT_FOUND;
              end else begin
                cmd_o.fetch_rd = 1'b1;
                state_d        = S_FETCH;
              end
            end
            default: begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_CLEARED;
            end
          endcase
        end
      end
      S_CMP: begin
        if (stat_i.hit) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          if (stat_i.op == OP_INSERT) begin
            cmd_o.upd_wr = 1'b1;
            cmd_o.status = ST_UPDATED;
          end else begin
            cmd_o.status = ST_FOUND;
          end
        end else begin
          cmd_o.srch_step = 1'b1;
          state_d         = S_SEARCH;
        end
      end
      S_FETCH: begin
        cmd_o.emit   = 1'b1;
        cmd_o.status = ST_FOUND;
        state_d      = S_IDLE;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.shift_last) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        cmd_o.ins_wr = 1'b1;
        cmd_o.emit   = 1'b1;
        cmd_o.status = ST_INSERTED;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  // Only inserts move entries
  a_shift_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (stat_i.op == OP_INSERT))
    else $error("shift running for a non-insert request");

  // Every result ends the request
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == S_IDLE))
    else $error("result emitted while request continues");

endmodule

// ===== rtl/sknt_datapath.sv =====
// Datapath of the sorted key node table: key/value memories, search window,
// shift pointer, count, capacity register and result registers. Depends on sknt_pkg.
module sknt_datapath import sknt_pkg::*; #(
  parameter int unsigned NODE_DEPTH = MaxEntriesDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output node_stat_t         stat_o,
  input  logic [1:0]         operation_i,
  input  logic [63:0]        search_key_i,
  input  logic [63:0]        entry_value_i,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_wdata_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [9:0]  result_index_o,
  output logic [63:0]        found_key_o,
  output logic [63:0]        result_value_o,
  output logic [8:0]         entry_count_o
);

  localparam int unsigned AW   = $clog2(NODE_DEPTH);
  localparam int unsigned CW   = $clog2(NODE_DEPTH + 1);
  localparam int unsigned CmpW = (CW > 9) ? CW : 9;

  // Storage
  logic [63:0]           key_mem [NODE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem [NODE_DEPTH];

  // Request and search registers
  op_e                   op_q;
  logic [63:0]           key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CW-1:0]         lo1_q, hi_q;  // lo1 is the low bracket plus one
  logic [AW-1:0]         mid_q, j_q;
  logic [CW-1:0]         count_q, count_d;
  logic [8:0]            cap_q;
  logic [63:0]           rdk_q;
  logic [VALUE_BITS-1:0] rdv_q;

  // Result registers
  logic                  done_q;
  status_e               status_q;
  logic [9:0]            idx_q;
  logic [63:0]           rkey_q;
  logic [VALUE_BITS-1:0] rval_q;
  logic [8:0]            rcnt_q;

  // Probe slot: lo + (hi - lo) / 2 with lo = lo1 - 1
  logic [CW:0]   diff, mid_w;
  logic [AW-1:0] mid_c, fetch_addr, cnt_m1;
  logic [AW:0]   jp1;

  assign diff   = {1'b0, hi_q} - {1'b0, lo1_q} + 1'b1;
  assign mid_w  = {1'b0, lo1_q} + (diff >> 1) - 1'b1;
  assign mid_c  = mid_w[AW-1:0];
  assign fetch_addr = (op_q == OP_LOWER) ? AW'(lo1_q - 1'b1) : AW'(hi_q);
  assign cnt_m1 = AW'(count_q - 1'b1);
  assign jp1    = {1'b0, j_q} + 1'b1;

  // Status to controller
  always_comb begin
    stat_o.op         = op_q;
    stat_o.open       = (hi_q > lo1_q);
    stat_o.hit        = (rdk_q == key_q);
    stat_o.full       = (CmpW'(count_q) >= CmpW'(cap_q)) ||
                        (count_q == CW'(NODE_DEPTH));
    stat_o.pos_lt_cnt = (lo1_q < count_q);
    stat_o.shift_last = (CW'(j_q) == lo1_q);
    stat_o.lb_miss    = (lo1_q == '0);
    stat_o.ub_miss    = (hi_q >= count_q);
  end

  // Memory port selection
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [63:0]           wr_key;
  logic [VALUE_BITS-1:0] wr_val;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_c;
    if (cmd_i.srch_rd) begin
      rd_en = 1'b1;
    end else if (cmd_i.fetch_rd) begin
      rd_en   = 1'b1;
      rd_addr = fetch_addr;
    end else if (cmd_i.shift_init) begin
      rd_en   = 1'b1;
      rd_addr = cnt_m1;
    end else if (cmd_i.shift_step && !stat_o.shift_last) begin
      rd_en   = 1'b1;
      rd_addr = j_q - 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lo1_q[AW-1:0];
    wr_key  = key_q;
    wr_val  = val_q;
    if (cmd_i.shift_step) begin
      wr_en   = 1'b1;
      wr_addr = jp1[AW-1:0];
      wr_key  = rdk_q;
      wr_val  = rdv_q;
    end else if (cmd_i.ins_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.upd_wr) begin
      wr_en   = 1'b1;
      wr_addr = mid_q;
    end
  end

  // Key and value memories, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rdk_q <= key_mem[rd_addr];
      rdv_q <= val_mem[rd_addr];
    end
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.ins_wr) begin
      count_d = count_q + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CapReset;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.emit;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Request capture, search window and shift pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      key_q <= search_key_i;
      val_q <= entry_value_i[VALUE_BITS-1:0];
      lo1_q <= '0;
      hi_q  <= count_q;
    end
    if (cmd_i.srch_step) begin
      if (rdk_q < key_q) begin
        lo1_q <= CW'(mid_q) + 1'b1;
      end else begin
        hi_q <= CW'(mid_q);
      end
    end
    if (cmd_i.srch_rd) begin
      mid_q <= mid_c;
    end else if (cmd_i.fetch_rd) begin
      mid_q <= fetch_addr;
    end
    if (cmd_i.shift_init) begin
      j_q <= cnt_m1;
    end else if (cmd_i.shift_step) begin
      j_q <= j_q - 1'b1;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      rcnt_q   <= 9'(count_d);
      unique case (cmd_i.status)
        ST_INSERTED: begin
          idx_q  <= 10'(lo1_q);
          rkey_q <= key_q;
          rval_q <= val_q;
        end
        ST_UPDATED: begin
          idx_q  <= 10'(mid_q);
          rkey_q <= key_q;
          rval_q <= val_q;
        end
        ST_FOUND: begin
          idx_q  <= 10'(mid_q);
          rkey_q <= rdk_q;
          rval_q <= rdv_q;
        end
        ST_NOT_FOUND: begin
          idx_q  <= (op_q == OP_LOWER) ? '1 : 10'(count_q);
          rkey_q <= '0;
          rval_q <= '0;
        end
        ST_FULL: begin
          idx_q  <= 10'(lo1_q);
          rkey_q <= '0;
          rval_q <= '0;
        end
        default: begin
          idx_q  <= '0;
          rkey_q <= '0;
          rval_q <= '0;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_index_o = idx_q;
  assign found_key_o    = rkey_q;
  assign result_value_o = 64'(rval_q);
  assign entry_count_o  = rcnt_q;

  // Count stays within the array
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NODE_DEPTH))
    else $error("entry count beyond array depth");

  // An insert result comes with the count one higher
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_INSERTED) |-> (count_q == CW'($past(count_q) + 1'b1)))
    else $error("insert result without count increment");

  // A full result leaves the count alone
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> (count_q == $past(count_q)))
    else $error("count changed on full result");

  // Shift pointer stays between insert slot and top entry
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_step |-> ((CW'(j_q) >= lo1_q) && (CW'(j_q) < count_q)))
    else $error("shift pointer out of range");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sorted_key_node_table: directed table, then random phases.
// Checks results against its own node model or a fixed row's want; needs sknt_pkg.
module tb_top;
  import sknt_pkg::*;

  localparam int NODE_SLOTS   = MaxEntriesDef;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_TICKS = 300;
  localparam logic [63:0] KEY_MAX = '1;

  // One result of the node, as the ports show it
  typedef struct packed {
    status_e     status;
    logic [9:0]  index;
    logic [63:0] key;
    logic [63:0] value;
    logic [8:0]  count;
  } node_result_t;

  // One directed request; want is used only when fixed is set
  typedef struct packed {
    op_e          op;
    logic [63:0]  key;
    logic [63:0]  value;
    logic         set_cap;
    logic [8:0]   cap;
    logic         fixed;
    node_result_t want;
  } node_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  op_e         operation_i;
  logic [63:0] search_key_i;
  logic [63:0] entry_value_i;
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic signed [9:0] result_index_o;
  logic [63:0] found_key_o;
  logic [63:0] result_value_o;
  logic [8:0]  entry_count_o;

  // Model of the node
  logic [63:0] key_store [NODE_SLOTS];
  logic [63:0] val_store [NODE_SLOTS];
  int          node_count = 0;
  logic [8:0]  cap_reg = CapReset;

  node_result_t awaited_results [$];
  node_row_t    directed_rows [$];
  logic         next_cap_set = 1'b0;
  logic [8:0]   next_cap = '0;
  logic         typed_valid = 1'b0;
  node_result_t typed_want;
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;

  sorted_key_node_table DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .search_key_i   (search_key_i),
    .entry_value_i  (entry_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .result_index_o (result_index_o),
    .found_key_o    (found_key_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Binary search over the used slots: exact hit, else the low or high bracket
  function automatic int probe_slot(logic [63:0] key, bit want_upper, output bit hit);
    int lo;
    int hi;
    int mid;
    lo  = -1;
    hi  = node_count;
    hit = 1'b0;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (key_store[mid] == key) begin
        hit = 1'b1;
        return mid;
      end
      if (key_store[mid] < key) lo = mid;
      else hi = mid;
    end
    return want_upper ? hi : lo;
  endfunction

  // Apply one request to the model node and return the result it gives
  function automatic node_result_t apply_to_node(op_e op, logic [63:0] key,
                                                 logic [63:0] value);
    node_result_t res;
    int           slot;
    int           cap;
    bit           hit;
    res = '0;
    res.status = ST_CLEARED;
    case (op)
      OP_INSERT: begin
        cap  = (cap_reg < NODE_SLOTS) ? int'(cap_reg) : NODE_SLOTS;
        slot = probe_slot(key, 1'b0, hit);
        if (hit) begin
          val_store[slot] = value;
          res.status = ST_UPDATED;
          res.index  = 10'(slot);
          res.key    = key;
          res.value  = value;
        end else if (node_count >= cap) begin
          res.status = ST_FULL;
          res.index  = 10'(slot + 1);
        end else begin
          slot = slot + 1;
          for (int j = node_count; j > slot; j--) begin
            key_store[j] = key_store[j - 1];
            val_store[j] = val_store[j - 1];
          end
          key_store[slot] = key;
          val_store[slot] = value;
          node_count++;
          res.status = ST_INSERTED;
          res.index  = 10'(slot);
          res.key    = key;
          res.value  = value;
        end
      end
      OP_LOWER, OP_UPPER: begin
        slot = probe_slot(key, op == OP_UPPER, hit);
        res.index = 10'(slot);
        if (slot < 0 || slot >= node_count) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status = ST_FOUND;
          res.key    = key_store[slot];
          res.value  = val_store[slot];
        end
      end
      default: begin
        node_count = 0;
      end
    endcase
    res.count = 9'(node_count);
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Result check, capacity tracking and prediction, all on the rising edge
  always @(posedge clk_i) begin
    node_result_t want;
    node_result_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request outstanding, status %0d",
                   $time, status_o);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 64'(want.status), 64'(status_o));
          check_field("result_index", 64'(want.index), 64'(unsigned'(result_index_o)));
          check_field("found_key", want.key, found_key_o);
          check_field("result_value", want.value, result_value_o);
          check_field("entry_count", 64'(want.count), 64'(entry_count_o));
        end
      end
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (start && !busy) begin
        predicted = apply_to_node(operation_i, search_key_i, entry_value_i);
        awaited_results.push_back(typed_valid ? typed_want : predicted);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Present one request from a falling edge until it is taken
  task automatic drive_request(op_e op, logic [63:0] key, logic [63:0] value);
    start         <= 1'b1;
    operation_i   <= op;
    search_key_i  <= key;
    entry_value_i <= value;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_requests();
    start <= 1'b0;
    do @(negedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic write_capacity(logic [8:0] cap);
    drain_requests();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic void capacity_before_next(logic [8:0] cap);
    next_cap_set = 1'b1;
    next_cap     = cap;
  endfunction

  function automatic void push_row(op_e op, logic [63:0] key, logic [63:0] value,
                                   logic fixed, node_result_t want);
    node_row_t row;
    row.op      = op;
    row.key     = key;
    row.value   = value;
    row.set_cap = next_cap_set;
    row.cap     = next_cap;
    row.fixed   = fixed;
    row.want    = want;
    next_cap_set = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void fixed_row(op_e op, logic [63:0] key, logic [63:0] value,
                                    status_e st, int idx, logic [63:0] rkey,
                                    logic [63:0] rvalue, int cnt);
    node_result_t want;
    want.status = st;
    want.index  = 10'(idx);
    want.key    = rkey;
    want.value  = rvalue;
    want.count  = 9'(cnt);
    push_row(op, key, value, 1'b1, want);
  endfunction

  function automatic void open_row(op_e op, logic [63:0] key, logic [63:0] value);
    push_row(op, key, value, 1'b0, '0);
  endfunction

  // Keys: a reuse_pct share of held keys and their neighbours, some extremes, rest random
  function automatic logic [63:0] pick_key(int reuse_pct);
    logic [63:0] k;
    int          sel;
    sel = $urandom_range(99);
    k   = {$urandom, $urandom};
    if (node_count > 0 && sel < reuse_pct) begin
      k = key_store[$urandom_range(node_count - 1)];
      if (sel % 4 == 1) k = k + 64'd1;
      else if (sel % 4 == 2) k = k - 64'd1;
    end else if (sel >= 95) begin
      k = (sel < 97) ? 64'(sel - 95) : ~64'(99 - sel);
    end
    return k;
  endfunction

  function automatic logic [63:0] pick_value();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic op_e pick_op(int insert_pct, int clear_pct);
    int sel;
    sel = $urandom_range(99);
    if (sel < clear_pct) return OP_CLEAR;
    if (sel < clear_pct + insert_pct) return OP_INSERT;
    return ($urandom_range(1) == 0) ? OP_LOWER : OP_UPPER;
  endfunction

  // One random phase at a given sender idle rate and request mix
  task automatic run_phase(int n_items, int idle_pct, int insert_pct, int clear_pct,
                           int reuse_pct);
    int gap;
    for (int i = 0; i < n_items; i++) begin
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) idle_cycles(gap);
      if ($urandom_range(99) == 0) drain_requests();
      drive_request(pick_op(insert_pct, clear_pct), pick_key(reuse_pct), pick_value());
    end
  endtask

  initial begin
    start         = 1'b0;
    operation_i   = OP_INSERT;
    search_key_i  = '0;
    entry_value_i = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    typed_want    = '0;
    rst_ni        = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty node, extremes, update, exact and bracket lookups, clear
    fixed_row(OP_LOWER, '0, '0, ST_NOT_FOUND, -1, '0, '0, 0);
    fixed_row(OP_UPPER, KEY_MAX, KEY_MAX, ST_NOT_FOUND, 0, '0, '0, 0);
    fixed_row(OP_INSERT, 64'h8000_0000_0000_0000, 64'd1, ST_INSERTED, 0,
              64'h8000_0000_0000_0000, 64'd1, 1);
    fixed_row(OP_INSERT, '0, KEY_MAX, ST_INSERTED, 0, '0, KEY_MAX, 2);
    fixed_row(OP_INSERT, KEY_MAX, '0, ST_INSERTED, 2, KEY_MAX, '0, 3);
    fixed_row(OP_INSERT, '0, 64'd5, ST_UPDATED, 0, '0, 64'd5, 3);
    open_row(OP_LOWER, 64'd1, KEY_MAX);
    open_row(OP_UPPER, 64'd1, '0);
    open_row(OP_LOWER, KEY_MAX, '0);
    open_row(OP_UPPER, '0, KEY_MAX);
    open_row(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    open_row(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    open_row(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    open_row(OP_LOWER, 64'h7FFF_FFFF_FFFF_FFFE, '0);
    open_row(OP_UPPER, 64'h8000_0000_0000_0001, '0);
    fixed_row(OP_CLEAR, KEY_MAX, KEY_MAX, ST_CLEARED, 0, '0, '0, 0);
    fixed_row(OP_LOWER, KEY_MAX, '0, ST_NOT_FOUND, -1, '0, '0, 0);
    fixed_row(OP_INSERT, 64'd5, 64'd7, ST_INSERTED, 0, 64'd5, 64'd7, 1);
    fixed_row(OP_LOWER, 64'd4, '0, ST_NOT_FOUND, -1, '0, '0, 1);
    fixed_row(OP_UPPER, 64'd6, '0, ST_NOT_FOUND, 1, '0, '0, 1);
    // Small capacity: full on a new key, update still allowed
    capacity_before_next(9'd2);
    fixed_row(OP_INSERT, 64'd9, 64'd11, ST_INSERTED, 1, 64'd9, 64'd11, 2);
    fixed_row(OP_INSERT, 64'd1, 64'd3, ST_FULL, 0, '0, '0, 2);
    fixed_row(OP_INSERT, 64'd5, KEY_MAX, ST_UPDATED, 0, 64'd5, KEY_MAX, 2);
    open_row(OP_LOWER, KEY_MAX, '0);
    open_row(OP_UPPER, '0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_cap) write_capacity(directed_rows[i].cap);
      typed_valid = directed_rows[i].fixed;
      typed_want  = directed_rows[i].want;
      drive_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value);
    end
    typed_valid = 1'b0;

    // Random phases over several capacities
    write_capacity(9'd256);
    run_phase(120, 0, 50, 3, 45);
    write_capacity(9'd5);
    run_phase(120, 86, 55, 5, 50);
    write_capacity(9'd0);
    run_phase(40, 7, 60, 5, 40);
    // Fill to the last slot and beyond
    write_capacity(9'd511);
    drive_request(OP_CLEAR, pick_key(0), pick_value());
    run_phase(340, 0, 95, 0, 10);
    // Capacity now below the count
    write_capacity(9'd3);
    run_phase(60, 86, 60, 0, 50);
    write_capacity(9'd1);
    run_phase(60, 7, 50, 10, 50);

    drain_requests();
    repeat (SETTLE_TICKS) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sknt_pkg.sv
rtl/sknt_ctrl.sv
rtl/sknt_datapath.sv
rtl/sorted_key_node_table.sv
verif/tb_top.sv
